[rtl/golay_24_12_decoder_macros.svh]
// assertion macros for the extended golay decoder
`ifndef GOLAY_24_12_DECODER_MACROS_SVH
`define GOLAY_24_12_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define GOL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define GOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GOL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define GOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/gol_pkg.sv]
`timescale 1ns / 1ps

package gol_pkg;

    localparam int DATA_W = 12;
    localparam int WORD_W = 24;
    localparam int CNT_W  = 4;

    localparam logic [DATA_W-1:0] ENC_ROWS [DATA_W] = '{
        12'hC75, 12'h49F, 12'hD4B, 12'h6E3, 12'h9B3, 12'hB66,
        12'hECC, 12'h1ED, 12'h3DA, 12'h7B4, 12'hB1D, 12'hE3A
    };

    localparam logic [DATA_W-1:0] DEC_ROWS [DATA_W] = '{
        12'h49F, 12'h93E, 12'h6E3, 12'hDC6, 12'hF13, 12'hAB9,
        12'h1ED, 12'h3DA, 12'h7B4, 12'hF68, 12'hA4F, 12'hC75
    };

    typedef struct packed {
        logic [DATA_W-1:0] syn;
        logic [DATA_W-1:0] inv;
    } t_syn;

    typedef struct packed {
        logic [WORD_W-1:0] pattern;
        logic              uncorrectable;
    } t_fix;

    function automatic logic [CNT_W-1:0] pop12(input logic [DATA_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int b = 0; b < DATA_W; b++) begin
            n = n + CNT_W'(v[b]);
        end
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] enc_mul(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < DATA_W; b++) begin
            if (v[b]) begin
                acc = acc ^ ENC_ROWS[b];
            end
        end
        return acc;
    endfunction

    function automatic logic [DATA_W-1:0] dec_mul(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < DATA_W; b++) begin
            if (v[b]) begin
                acc = acc ^ DEC_ROWS[b];
            end
        end
        return acc;
    endfunction

endpackage

[rtl/golay_24_12_decoder.sv]
`timescale 1ns / 1ps
// channel   | transaction              | ports
// ----------+--------------------------+------------------------------------------------
// codeword  | start high, busy low     | i_received_word
// result    | o_done high, one cycle   | o_corrected_data, o_error_pattern,
//           |                          | o_uncorrectable
//
// one codeword per cycle; o_done follows each accepting edge
// latency set by the input register and the result register around the decode logic
// busy is raised only while reset is held, the pipeline has no stall path
// synchronous active-low reset clears the valid flags only
// results cannot be held off by the receiver

`include "golay_24_12_decoder_macros.svh"

module golay_24_12_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [gol_pkg::WORD_W-1:0] i_received_word,
    output logic                       o_done,
    output logic [gol_pkg::DATA_W-1:0] o_corrected_data,
    output logic [gol_pkg::WORD_W-1:0] o_error_pattern,
    output logic                       o_uncorrectable
);

    logic                       r_in_valid;
    logic [gol_pkg::WORD_W-1:0] r_word;
    logic                       r_out_valid;
    logic [gol_pkg::DATA_W-1:0] r_data;
    logic [gol_pkg::WORD_W-1:0] r_pattern;
    logic                       r_uncorr;
    logic [gol_pkg::DATA_W-1:0] n_data;
    gol_pkg::t_syn              syn;
    gol_pkg::t_fix              fix;

    assign busy = ~i_rst_n;

    gol_syndrome u_syndrome (
        .i_word (r_word),
        .o_syn  (syn)
    );

    gol_locate u_locate (
        .i_syn (syn),
        .o_fix (fix)
    );

    assign n_data = fix.uncorrectable ? '0
                  : (r_word[gol_pkg::DATA_W-1:0] ^ fix.pattern[gol_pkg::DATA_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start & ~busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start & ~busy) begin
            r_word <= i_received_word;
        end
        r_data    <= n_data;
        r_pattern <= fix.pattern;
        r_uncorr  <= fix.uncorrectable;
    end

    assign o_done           = r_out_valid;
    assign o_corrected_data = r_data;
    assign o_error_pattern  = r_pattern;
    assign o_uncorrectable  = r_uncorr;

    `GOL_ASSERT_NEXT(a_accept_to_done, i_clk, i_rst_n, r_in_valid, o_done, "result strobe missing")
    `GOL_ASSERT_IMP(a_uncorr_zero, i_clk, i_rst_n, o_done && o_uncorrectable, (o_error_pattern == '0) && (o_corrected_data == '0), "uncorrectable result not zeroed")
    `GOL_ASSERT_IMP(a_weight, i_clk, i_rst_n, o_done && !o_uncorrectable, $countones(o_error_pattern) <= 3, "error pattern weight above three")
    `GOL_ASSERT_IMP(a_data_fix, i_clk, i_rst_n, o_done && !o_uncorrectable, o_corrected_data == ($past(r_word[gol_pkg::DATA_W-1:0]) ^ o_error_pattern[gol_pkg::DATA_W-1:0]), "corrected data mismatch")

endmodule

[rtl/gol_syndrome.sv]
`timescale 1ns / 1ps

module gol_syndrome (
    input  logic [gol_pkg::WORD_W-1:0] i_word,
    output gol_pkg::t_syn              o_syn
);

    logic [gol_pkg::DATA_W-1:0] syn;

    assign syn       = i_word[gol_pkg::WORD_W-1:gol_pkg::DATA_W]
                     ^ gol_pkg::enc_mul(i_word[gol_pkg::DATA_W-1:0]);
    assign o_syn.syn = syn;
    assign o_syn.inv = gol_pkg::dec_mul(syn);

endmodule

[rtl/gol_locate.sv]
`timescale 1ns / 1ps

module gol_locate (
    input  gol_pkg::t_syn i_syn,
    output gol_pkg::t_fix o_fix
);

    logic                       syn_hit;
    logic                       inv_hit;
    logic                       enc_hit;
    logic                       dec_hit;
    logic [gol_pkg::WORD_W-1:0] enc_mask;
    logic [gol_pkg::WORD_W-1:0] dec_mask;
    logic [gol_pkg::DATA_W-1:0] t_enc;
    logic [gol_pkg::DATA_W-1:0] t_dec;
    logic [gol_pkg::DATA_W-1:0] one_hot;

    assign syn_hit = gol_pkg::pop12(i_syn.syn) <= gol_pkg::CNT_W'(3);
    assign inv_hit = gol_pkg::pop12(i_syn.inv) <= gol_pkg::CNT_W'(3);

    // lowest matching row wins
    always_comb begin
        enc_hit  = 1'b0;
        dec_hit  = 1'b0;
        enc_mask = '0;
        dec_mask = '0;
        t_enc    = '0;
        t_dec    = '0;
        one_hot  = '0;
        for (int i = gol_pkg::DATA_W - 1; i >= 0; i--) begin
            one_hot    = '0;
            one_hot[i] = 1'b1;
            t_enc      = i_syn.syn ^ gol_pkg::ENC_ROWS[i];
            t_dec      = i_syn.inv ^ gol_pkg::DEC_ROWS[i];
            if (gol_pkg::pop12(t_enc) <= gol_pkg::CNT_W'(2)) begin
                enc_hit  = 1'b1;
                enc_mask = {t_enc, one_hot};
            end
            if (gol_pkg::pop12(t_dec) <= gol_pkg::CNT_W'(2)) begin
                dec_hit  = 1'b1;
                dec_mask = {one_hot, t_dec};
            end
        end
    end

    always_comb begin
        o_fix.pattern       = '0;
        o_fix.uncorrectable = 1'b0;
        if (syn_hit) begin
            o_fix.pattern = {i_syn.syn, {gol_pkg::DATA_W{1'b0}}};
        end else if (enc_hit) begin
            o_fix.pattern = enc_mask;
        end else if (inv_hit) begin
            o_fix.pattern = {{gol_pkg::DATA_W{1'b0}}, i_syn.inv};
        end else if (dec_hit) begin
            o_fix.pattern = dec_mask;
        end else begin
            o_fix.uncorrectable = 1'b1;
        end
    end

endmodule
